FILE: sv/sevq_pkg.sv
// shared types and codes for the sorted event queue
package sevq_pkg;

	localparam logic [1:0] CMD_ADD  = 2'd0;
	localparam logic [1:0] CMD_DEL  = 2'd1;
	localparam logic [1:0] CMD_READ = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_RANK      = 2'd3;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] event_id;
		logic [31:0] event_time;
		logic [3:0]  rank;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] out_id;
		logic [31:0] out_time;
		logic [4:0]  count;
	} rsp_t;

	typedef struct packed {
		logic [31:0] ev_id;
		logic [31:0] ev_time;
	} entry_t;

	typedef struct packed {
		logic        add;
		logic        del;
		logic [31:0] ev_id;
		logic [31:0] ev_time;
	} cell_ctl_t;

endpackage

FILE: sv/sevq_cell.sv
// one slot of the sorted chain: compare against the command and shift left or right
module sevq_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  sevq_pkg::cell_ctl_t ctl,
	input  sevq_pkg::entry_t   lft_ent,
	input  logic               lft_valid,
	input  logic               lft_ins,
	input  logic               lft_del,
	input  sevq_pkg::entry_t   rgt_ent,
	input  logic               rgt_valid,
	output sevq_pkg::entry_t   ent,
	output logic               valid,
	output logic               ins,
	output logic               del
);
	import sevq_pkg::*;

	entry_t ent_q;
	logic   valid_q;
	entry_t new_ent;

	assign new_ent = '{ev_id: ctl.ev_id, ev_time: ctl.ev_time};

	// at or past the insertion point, and at or past the first id match
	assign ins = !valid_q || (ent_q.ev_time > ctl.ev_time);
	assign del = lft_del || (valid_q && (ent_q.ev_id == ctl.ev_id));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.add && ins) begin
			valid_q <= valid_q | lft_valid;
		end else if (ctl.del && del) begin
			valid_q <= rgt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.add && ins) begin
			ent_q <= lft_ins ? lft_ent : new_ent;
		end else if (ctl.del && del) begin
			ent_q <= rgt_ent;
		end
	end

	assign ent   = ent_q;
	assign valid = valid_q;

endmodule

FILE: sv/sorted_event_queue.sv
// top level of the sorted event queue: cell chain, count and result register
//
// Keeps up to ENTRIES events (id, timestamp) in ascending timestamp order in a
// row of cells. Each command beat on req (valid/stall) is add, delete by id or
// read at rank; each gives exactly one result beat on rsp (valid/stall).
// Add places the event after all stored events with an equal or earlier
// timestamp, or answers full. Delete removes the earliest event with that id,
// or answers not found. Read returns the event at a rank, or rank out of range.
// Every result carries the count of stored events after the command.
// Every cell compares and shifts in parallel, so a command completes in the
// cycle it is accepted; its result is then presented from the result
// register. One command per cycle is taken as long as rsp is not stalled.
// While a result waits under rsp_stall, req_stall is high; once the result is
// taken, the next command is accepted in the same cycle.
// Reset empties the queue (count zero) and drops any pending result.
module sorted_event_queue #(
	parameter int ENTRIES = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  sevq_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output sevq_pkg::rsp_t rsp
);
	import sevq_pkg::*;

	localparam int CW = $clog2(ENTRIES + 1);

	entry_t          ent_w   [ENTRIES];
	logic            valid_w [ENTRIES];
	logic            ins_w   [ENTRIES];
	logic            del_w   [ENTRIES];
	entry_t          lft_ent [ENTRIES];
	logic            lft_vld [ENTRIES];
	logic            lft_ins [ENTRIES];
	logic            lft_del [ENTRIES];
	entry_t          rgt_ent [ENTRIES];
	logic            rgt_vld [ENTRIES];

	logic [CW-1:0]   count_q;
	logic [CW-1:0]   count_nx;
	logic [CW+4:0]   count_ext;
	logic            rsp_valid_q;
	rsp_t            rsp_q;
	rsp_t            rsp_nx;
	cell_ctl_t       ctl;
	logic            accept;
	logic            full;
	logic            found;
	logic            rd_hit;
	entry_t          rd_ent;

	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;
	assign full      = (count_q == CW'(ENTRIES));
	assign found     = del_w[ENTRIES-1];

	assign ctl.add     = accept && (req.cmd == CMD_ADD) && !full;
	assign ctl.del     = accept && (req.cmd == CMD_DEL);
	assign ctl.ev_id   = req.event_id;
	assign ctl.ev_time = req.event_time;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign lft_ent[i] = '0;
			assign lft_vld[i] = 1'b1;
			assign lft_ins[i] = 1'b0;
			assign lft_del[i] = 1'b0;
		end else begin : g_mid
			assign lft_ent[i] = ent_w[i-1];
			assign lft_vld[i] = valid_w[i-1];
			assign lft_ins[i] = ins_w[i-1];
			assign lft_del[i] = del_w[i-1];
		end
		if (i == ENTRIES - 1) begin : g_last
			assign rgt_ent[i] = '0;
			assign rgt_vld[i] = 1'b0;
		end else begin : g_inner
			assign rgt_ent[i] = ent_w[i+1];
			assign rgt_vld[i] = valid_w[i+1];
		end

		sevq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.lft_ent   (lft_ent[i]),
			.lft_valid (lft_vld[i]),
			.lft_ins   (lft_ins[i]),
			.lft_del   (lft_del[i]),
			.rgt_ent   (rgt_ent[i]),
			.rgt_valid (rgt_vld[i]),
			.ent       (ent_w[i]),
			.valid     (valid_w[i]),
			.ins       (ins_w[i]),
			.del       (del_w[i])
		);
	end

	// rank select over the cells
	always_comb begin
		rd_hit = 1'b0;
		rd_ent = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (valid_w[i] && (32'(req.rank) == i)) begin
				rd_hit = 1'b1;
				rd_ent = ent_w[i];
			end
		end
	end

	always_comb begin
		rsp_nx   = '0;
		count_nx = count_q;
		unique case (req.cmd)
			CMD_ADD: begin
				if (full) begin
					rsp_nx.status = ST_FULL;
				end else begin
					count_nx = count_q + CW'(1);
				end
			end
			CMD_DEL: begin
				if (found) begin
					count_nx = count_q - CW'(1);
				end else begin
					rsp_nx.status = ST_NOT_FOUND;
				end
			end
			CMD_READ: begin
				if (rd_hit) begin
					rsp_nx.out_id   = rd_ent.ev_id;
					rsp_nx.out_time = rd_ent.ev_time;
				end else begin
					rsp_nx.status = ST_RANK;
				end
			end
			default: begin
				rsp_nx.status = ST_OK;
			end
		endcase
		count_ext    = (CW+5)'(count_nx);
		rsp_nx.count = count_ext[4:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_nx;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_nx;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
